// ===== sv/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared widths, status and command codes and register indexes of the
// first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int ADDR_W      = 32;
  localparam int SIZE_W      = 24;
  localparam int COUNT_W     = 7;
  localparam int STATUS_W    = 2;
  localparam int CFG_INDEX_W = 1;
  localparam int ALIGN_BYTES = 8;
  localparam int ALIGN_BITS  = 3;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t STATUS_OK         = 2'd0;
  localparam status_t STATUS_NO_SPACE   = 2'd1;
  localparam status_t STATUS_TABLE_FULL = 2'd2;
  localparam status_t STATUS_NOT_FOUND  = 2'd3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_HEAP_BASE  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEAP_BYTES = 1'd1;

endpackage

// ===== sv/first_fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit heap allocator over an address-ordered block table in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   An item (command, request_size, free_address) is taken at a clock edge
//   with start high and busy low. busy stays high until the result is shown.
//   The result (status, data_address, used_bytes, total_bytes, block_count)
//   is valid for exactly one cycle while done is high; busy drops in that
//   same cycle, so the next item may be taken at the edge that ends it.
//   The receiver cannot stall the block and must take the result on done.
//   Configuration (heap_base, heap_bytes) is written through config_write,
//   config_index and config_data while no item is in flight.
// Table access:
//   The table is one RAM; the scan reads one entry a cycle and the insert
//   or removal moves one entry a cycle. An early fit leaves a longer shift.
//   A full table or a free of zero goes straight to the result.
// Reset:
//   rst clears the block count, the used byte total and both registers;
//   table entries are not cleared, only entries below the count are read.
// ----------------------------------------------------------------------------
module first_fit_block_allocator
  import ffba_pkg::*;
#(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 16,
  parameter int OFFSET_BITS  = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   config_write,
  input  logic [CFG_INDEX_W-1:0] config_index,
  input  logic [ADDR_W-1:0]      config_data,
  input  logic                   start,
  output logic                   busy,
  input  logic                   command,
  input  logic [SIZE_W-1:0]      request_size,
  input  logic [ADDR_W-1:0]      free_address,
  output logic                   done,
  output status_t                status,
  output logic [ADDR_W-1:0]      data_address,
  output logic [SIZE_W-1:0]      used_bytes,
  output logic [SIZE_W-1:0]      total_bytes,
  output logic [COUNT_W-1:0]     block_count
);

  localparam int HDR  = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
  localparam int IW   = $clog2(MAX_BLOCKS);
  localparam int CW   = $clog2(MAX_BLOCKS + 1);
  localparam int RQW  = SIZE_W + 1;
  localparam int AW   = ((OFFSET_BITS > RQW) ? OFFSET_BITS : RQW) + 1;
  localparam int EW   = 2 * OFFSET_BITS;

  localparam logic [2:0] ST_IDLE       = 3'd0;
  localparam logic [2:0] ST_SCAN       = 3'd1;
  localparam logic [2:0] ST_TAIL       = 3'd2;
  localparam logic [2:0] ST_SHIFT_UP   = 3'd3;
  localparam logic [2:0] ST_INSERT     = 3'd4;
  localparam logic [2:0] ST_SHIFT_DOWN = 3'd5;
  localparam logic [2:0] ST_FINISH     = 3'd6;

  logic [2:0]             state;
  logic [CW-1:0]          live;
  logic [SIZE_W-1:0]      used_total;
  logic                   is_free;
  logic [RQW-1:0]         size_req;
  logic [ADDR_W-1:0]      key;
  logic [AW-1:0]          pos;
  logic [IW-1:0]          slot;
  logic [CW-1:0]          rd_idx;
  logic                   chk_valid;
  logic [IW-1:0]          chk_idx;
  logic [CW-1:0]          j;
  logic [CW-1:0]          j_dec;
  logic                   wr_pend;
  logic [IW-1:0]          wr_addr;

  logic [ADDR_W-1:0]      base_aligned;
  logic [OFFSET_BITS-1:0] root_size;
  logic [SIZE_W-1:0]      geom_total;

  logic                   ram_we;
  logic [IW-1:0]          ram_waddr;
  logic [EW-1:0]          ram_wdata;
  logic [IW-1:0]          ram_raddr;
  logic [EW-1:0]          ram_rdata;

  logic [OFFSET_BITS-1:0] ent_off;
  logic [OFFSET_BITS-1:0] ent_len;
  logic [AW-1:0]          gap;
  logic [AW-1:0]          tail;
  logic                   issue_scan;
  logic                   hit;
  logic [RQW-1:0]         size_round;

  ffba_geom #(
    .HEADER_BYTES (HEADER_BYTES),
    .OFFSET_BITS  (OFFSET_BITS)
  ) u_geom (
    .clk          (clk),
    .rst          (rst),
    .config_write (config_write),
    .config_index (config_index),
    .config_data  (config_data),
    .base_aligned (base_aligned),
    .root_size    (root_size),
    .total_bytes  (geom_total)
  );

  ffba_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy    = (state != ST_IDLE);
  assign ent_off = ram_rdata[EW-1:OFFSET_BITS];
  assign ent_len = ram_rdata[OFFSET_BITS-1:0];
  assign j_dec   = j - 1'b1;

  always_comb begin
    size_round = (RQW'(request_size) + RQW'(ALIGN_BYTES - 1)) & ~RQW'(ALIGN_BYTES - 1);
    gap        = (AW'(ent_off) >= pos) ? (AW'(ent_off) - pos) : '0;
    tail       = (AW'(root_size) >= pos) ? (AW'(root_size) - pos) : '0;
    issue_scan = (rd_idx < live);
    if (is_free) begin
      hit = chk_valid && (ADDR_W'(ent_off) == key);
    end else begin
      hit = chk_valid && (gap >= AW'(size_req));
    end
  end

  // reads always run ahead of or away from the pending write, so a shift
  // never reads an entry in the cycle it is written
  always_comb begin
    ram_raddr = rd_idx[IW-1:0];
    ram_we    = 1'b0;
    ram_waddr = wr_addr;
    ram_wdata = ram_rdata;
    case (state)
      ST_SHIFT_UP: begin
        ram_raddr = j_dec[IW-1:0];
        ram_we    = wr_pend;
      end
      ST_SHIFT_DOWN: begin
        ram_raddr = j[IW-1:0];
        ram_we    = wr_pend;
      end
      ST_INSERT: begin
        ram_we    = 1'b1;
        ram_waddr = slot;
        ram_wdata = {OFFSET_BITS'(pos), OFFSET_BITS'(size_req)};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      live       <= '0;
      used_total <= '0;
      done       <= 1'b0;
      chk_valid  <= 1'b0;
      wr_pend    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            is_free      <= (command == CMD_FREE);
            size_req     <= size_round + RQW'(HDR);
            key          <= free_address - base_aligned - ADDR_W'(HDR);
            pos          <= AW'(HDR);
            rd_idx       <= '0;
            chk_valid    <= 1'b0;
            data_address <= '0;
            status       <= STATUS_OK;
            if (command == CMD_FREE) begin
              state <= (free_address == '0) ? ST_FINISH : ST_SCAN;
            end else if (live >= CW'(MAX_BLOCKS)) begin
              status <= STATUS_TABLE_FULL;
              state  <= ST_FINISH;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (hit) begin
            slot      <= chk_idx;
            chk_valid <= 1'b0;
            wr_pend   <= 1'b0;
            if (is_free) begin
              used_total <= used_total - SIZE_W'(ent_len);
              j          <= CW'(chk_idx) + 1'b1;
              state      <= ST_SHIFT_DOWN;
            end else begin
              j     <= live;
              state <= ST_SHIFT_UP;
            end
          end else begin
            if (chk_valid && !is_free) begin
              pos <= AW'(ent_off) + AW'(ent_len);
            end
            chk_valid <= issue_scan;
            chk_idx   <= rd_idx[IW-1:0];
            if (issue_scan) begin
              rd_idx <= rd_idx + 1'b1;
            end
            // everything read and checked without a match
            if (!chk_valid && !issue_scan) begin
              if (is_free) begin
                status <= STATUS_NOT_FOUND;
                state  <= ST_FINISH;
              end else begin
                state <= ST_TAIL;
              end
            end
          end
        end
        ST_TAIL: begin
          if (tail < AW'(size_req)) begin
            status <= STATUS_NO_SPACE;
            state  <= ST_FINISH;
          end else begin
            slot    <= live[IW-1:0];
            j       <= live;
            wr_pend <= 1'b0;
            state   <= ST_SHIFT_UP;
          end
        end
        ST_SHIFT_UP: begin
          wr_pend <= (j > CW'(slot));
          wr_addr <= j[IW-1:0];
          if (j > CW'(slot)) begin
            j <= j_dec;
          end else if (!wr_pend) begin
            state <= ST_INSERT;
          end
        end
        ST_INSERT: begin
          live         <= live + 1'b1;
          used_total   <= SIZE_W'(RQW'(used_total) + size_req);
          data_address <= base_aligned + ADDR_W'(pos) + ADDR_W'(HDR);
          status       <= STATUS_OK;
          state        <= ST_FINISH;
        end
        ST_SHIFT_DOWN: begin
          wr_pend <= (j < live);
          wr_addr <= j_dec[IW-1:0];
          if (j < live) begin
            j <= j + 1'b1;
          end else if (!wr_pend) begin
            live   <= live - 1'b1;
            status <= STATUS_OK;
            state  <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          done        <= 1'b1;
          used_bytes  <= used_total;
          total_bytes <= geom_total;
          block_count <= COUNT_W'(live);
          state       <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live <= CW'(MAX_BLOCKS))
    else $error("block count above table depth");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INSERT) |=> (live == CW'($past(live) + 1'b1)))
    else $error("insert did not add one block");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still busy");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && status == STATUS_TABLE_FULL) |-> (live == CW'(MAX_BLOCKS)))
    else $error("table full reported with free slots");

  a_idle_used: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && !start) |=> $stable(used_total))
    else $error("used bytes changed while idle");

endmodule

// ===== sv/ffba_ram.sv =====
// ----------------------------------------------------------------------------
// ffba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffba_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/ffba_geom.sv =====
// ----------------------------------------------------------------------------
// ffba_geom
// Heap configuration registers and the derived geometry: aligned base,
// usable root size and the reported total bytes.
// ----------------------------------------------------------------------------
module ffba_geom
  import ffba_pkg::*;
#(
  parameter int HEADER_BYTES = 16,
  parameter int OFFSET_BITS  = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   config_write,
  input  logic [CFG_INDEX_W-1:0] config_index,
  input  logic [ADDR_W-1:0]      config_data,
  output logic [ADDR_W-1:0]      base_aligned,
  output logic [OFFSET_BITS-1:0] root_size,
  output logic [SIZE_W-1:0]      total_bytes
);

  localparam int HDR = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
  localparam int RW  = (OFFSET_BITS > SIZE_W) ? OFFSET_BITS : SIZE_W;
  localparam logic [OFFSET_BITS-1:0] ROOT_LIMIT =
    {{(OFFSET_BITS-ALIGN_BITS){1'b1}}, {ALIGN_BITS{1'b0}}};

  logic [ADDR_W-1:0]      heap_base;
  logic [SIZE_W-1:0]      heap_bytes;
  logic [ADDR_W:0]        base_wide;
  logic [ADDR_W:0]        end_wide;
  logic [SIZE_W-1:0]      span;
  logic [RW-1:0]          span_ext;
  logic [OFFSET_BITS-1:0] root_next;
  logic [SIZE_W-1:0]      total_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base  <= '0;
      heap_bytes <= '0;
    end else if (config_write) begin
      case (config_index)
        REG_HEAP_BASE:  heap_base  <= config_data;
        REG_HEAP_BYTES: heap_bytes <= config_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    base_wide = ({1'b0, heap_base} + (ADDR_W+1)'(ALIGN_BYTES - 1))
                & ~(ADDR_W+1)'(ALIGN_BYTES - 1);
    end_wide  = {1'b0, heap_base} + (ADDR_W+1)'(heap_bytes);
    // the span never exceeds heap_bytes, so it fits the size width
    if (end_wide >= base_wide) begin
      span = SIZE_W'(end_wide - base_wide) & ~SIZE_W'(ALIGN_BYTES - 1);
    end else begin
      span = '0;
    end
    span_ext = RW'(span);
    if (span_ext > RW'(ROOT_LIMIT)) begin
      root_next = ROOT_LIMIT;
    end else begin
      root_next = OFFSET_BITS'(span_ext);
    end
    if (root_next >= OFFSET_BITS'(HDR)) begin
      total_next = SIZE_W'(root_next - OFFSET_BITS'(HDR));
    end else begin
      total_next = '0;
    end
  end

  assign base_aligned = ADDR_W'(base_wide);

  always_ff @(posedge clk) begin
    root_size   <= root_next;
    total_bytes <= total_next;
  end

endmodule
